// ===== hw/rtl/tgcp_pkg.sv =====
// Shared types, codes and arithmetic helpers for the tile grid constraint propagator.
package tgcp_pkg;

    localparam int DEF_GRID_WIDTH  = 16;
    localparam int DEF_GRID_HEIGHT = 16;
    localparam int DEF_NUM_VALUES  = 4;

    // Forbid matrices are 4x4 bits: bit from*4+to
    localparam int FORBID_STRIDE = 4;
    localparam int NUM_DIRS      = 4;
    localparam int NUM_BANKS     = 5;

    localparam logic ACT_OBSERVE = 1'b0;
    localparam logic ACT_READ    = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_COORD = 2'd1;
    localparam logic [1:0] ST_VALUE = 2'd2;

    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_LEFT  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    // Role code equals the bank offset of that tile from the center tile, mod 5
    localparam logic [2:0] ROLE_CENTER = 3'd0;
    localparam logic [2:0] ROLE_RIGHT  = 3'd1;
    localparam logic [2:0] ROLE_DOWN   = 3'd2;
    localparam logic [2:0] ROLE_UP     = 3'd3;
    localparam logic [2:0] ROLE_LEFT   = 3'd4;

    typedef enum logic [2:0] {
        REG_ACTIVE_WIDTH  = 3'd0,
        REG_ACTIVE_HEIGHT = 3'd1,
        REG_VALUE_COUNT   = 3'd2,
        REG_FORBID_UP     = 3'd3,
        REG_FORBID_DOWN   = 3'd4,
        REG_FORBID_LEFT   = 3'd5,
        REG_FORBID_RIGHT  = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [4:0]                 active_width;
        logic [4:0]                 active_height;
        logic [2:0]                 value_count;
        logic [NUM_DIRS-1:0][15:0]  forbid;
    } t_cfg;

    function automatic logic [1:0] opp_dir(input logic [1:0] d);
        logic [1:0] r;
        unique case (d)
            DIR_UP:   r = DIR_DOWN;
            DIR_DOWN: r = DIR_UP;
            DIR_LEFT: r = DIR_RIGHT;
            default:  r = DIR_LEFT;
        endcase
        return r;
    endfunction

    // (x + 2y) mod 5: a tile and its four neighbors always fall in distinct banks
    function automatic logic [2:0] bank_of(input logic [5:0] x, input logic [5:0] y);
        logic [7:0]  s;
        logic [15:0] p;
        logic [7:0]  q;
        logic [7:0]  r;
        s = {2'b00, x} + {1'b0, y, 1'b0};
        p = 16'(s) * 16'd205;
        q = 8'(p >> 10);
        r = s - 8'(q * 8'd5);
        return r[2:0];
    endfunction

    // x / 5 for x below 64
    function automatic logic [3:0] col_div5(input logic [5:0] x);
        logic [9:0] p;
        p = 10'(x) * 10'd13;
        return 4'(p >> 6);
    endfunction

    function automatic logic [2:0] add_mod5(input logic [2:0] a, input logic [2:0] b);
        logic [3:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= 4'd5) ? 3'(s - 4'd5) : s[2:0];
    endfunction

    function automatic logic [2:0] sub_mod5(input logic [2:0] a, input logic [2:0] b);
        return add_mod5(a, 3'd5 - b);
    endfunction

endpackage

// ===== hw/rtl/tgcp_cfg_regs.sv =====
// Configuration register file: grid size, value count and forbid matrices.
module tgcp_cfg_regs
    import tgcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [2:0]  i_index,
    input  logic [15:0] i_data,
    output logic        o_ready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.active_width  <= 5'd16;
            r_cfg.active_height <= 5'd16;
            r_cfg.value_count   <= 3'd4;
            r_cfg.forbid        <= '0;
        end else if (i_valid && o_ready) begin
            unique case (t_reg_idx'(i_index))
                REG_ACTIVE_WIDTH:  r_cfg.active_width  <= i_data[4:0];
                REG_ACTIVE_HEIGHT: r_cfg.active_height <= i_data[4:0];
                REG_VALUE_COUNT:   r_cfg.value_count   <= i_data[2:0];
                REG_FORBID_UP:     r_cfg.forbid[DIR_UP]    <= i_data;
                REG_FORBID_DOWN:   r_cfg.forbid[DIR_DOWN]  <= i_data;
                REG_FORBID_LEFT:   r_cfg.forbid[DIR_LEFT]  <= i_data;
                REG_FORBID_RIGHT:  r_cfg.forbid[DIR_RIGHT] <= i_data;
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/tgcp_mask_bank.sv =====
// One bank of tile masks with per-bit write enables and a registered read port.
module tgcp_mask_bank #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 4
) (
    input  logic          i_clk,
    input  logic [DW-1:0] i_wen,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] r_rdata;

    assign o_rdata = r_rdata;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DW; i++) begin
            if (i_wen[i]) begin
                mem[i_waddr][i] <= i_wdata[i];
            end
        end
        r_rdata <= mem[i_raddr];
    end

endmodule

// ===== hw/rtl/tile_grid_constraint_propagator.sv =====
// Tile grid constraint propagator: per-tile allowed-value masks with neighbor propagation.
//
// After reset, busy stays high while every bank is filled with all ones; after that busy
// never rises again and the block takes one item per clock. Each result comes back with
// one o_done pulse, through the input register and then the result register; the receiver
// cannot stall. The masks live in five banks selected by (x + 2y) mod 5, so an observe
// writes the tile and its four neighbors in the same cycle, one write port per bank.
// Neighbor updates only clear bits, so they need no read. Configuration writes are always
// ready.
module tile_grid_constraint_propagator
    import tgcp_pkg::*;
#(
    parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
    parameter int NUM_VALUES  = DEF_NUM_VALUES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_action,
    input  logic [3:0]  i_x_pos,
    input  logic [3:0]  i_y_pos,
    input  logic [1:0]  i_tile_value,
    output logic        o_done,
    output logic [3:0]  o_allowed_mask,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int MASK_W = (NUM_VALUES < FORBID_STRIDE) ? NUM_VALUES : FORBID_STRIDE;
    localparam int XW     = $clog2(GRID_WIDTH);
    localparam int YW     = $clog2(GRID_HEIGHT);
    localparam int CPR    = (GRID_WIDTH + NUM_BANKS - 1) / NUM_BANKS;
    localparam int BDEPTH = GRID_HEIGHT * CPR;
    localparam int IW     = $clog2(BDEPTH);
    localparam logic [MASK_W-1:0] MASK_ALL = '1;

    t_cfg cfg;

    // fill pass after reset
    logic          r_fill;
    logic [IW-1:0] r_fill_addr;

    // input register
    logic       r_a_vld;
    logic       r_a_act;
    logic [3:0] r_a_x;
    logic [3:0] r_a_y;
    logic [1:0] r_a_v;

    // result register
    logic              r_b_vld;
    logic [1:0]        r_b_status;
    logic              r_b_rd;
    logic [2:0]        r_b_bank;
    logic [MASK_W-1:0] r_b_obs;

    logic              coord_ok;
    logic              val_ok;
    logic              do_obs;
    logic [1:0]        st;
    logic [XW-1:0]     xa;
    logic [YW-1:0]     ya;
    logic [2:0]        ctr_bank;
    logic [MASK_W-1:0] obs_mask;

    logic [XW-1:0]     n_x   [NUM_BANKS];
    logic [YW-1:0]     n_y   [NUM_BANKS];
    logic              n_on  [NUM_BANKS];
    logic [MASK_W-1:0] n_clr [NUM_BANKS];
    logic [IW-1:0]     n_idx [NUM_BANKS];
    logic              n_wr  [NUM_BANKS];
    logic [MASK_W-1:0] n_wen [NUM_BANKS];
    logic [MASK_W-1:0] n_dat [NUM_BANKS];

    logic [2:0]        b_role  [NUM_BANKS];
    logic [MASK_W-1:0] b_wen   [NUM_BANKS];
    logic [IW-1:0]     b_waddr [NUM_BANKS];
    logic [MASK_W-1:0] b_wdata [NUM_BANKS];
    logic [MASK_W-1:0] b_rdata [NUM_BANKS];
    logic [MASK_W-1:0] out_mask;

    assign busy = r_fill;

    tgcp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_ready (o_cfg_ready),
        .o_cfg   (cfg)
    );

    // walk every bank address once, writing all ones
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= 1'b1;
            r_fill_addr <= '0;
        end else if (r_fill) begin
            r_fill_addr <= r_fill_addr + IW'(1);
            if (r_fill_addr == IW'(BDEPTH - 1)) begin
                r_fill <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
        end
        r_a_act <= i_action;
        r_a_x   <= i_x_pos;
        r_a_y   <= i_y_pos;
        r_a_v   <= i_tile_value;
    end

    // Clear mask for the neighbor in direction d: forward rule of d, reverse rule of opposite
    function automatic logic [MASK_W-1:0] clr_mask(input t_cfg c, input logic [1:0] d,
                                                   input logic [1:0] v);
        logic [MASK_W-1:0] m;
        logic [1:0]        od;
        od = opp_dir(d);
        for (int t = 0; t < MASK_W; t++) begin
            m[t] = c.forbid[d][{v, 2'(t)}] | c.forbid[od][{2'(t), v}];
        end
        return m;
    endfunction

    always_comb begin
        coord_ok = (5'(r_a_x) < cfg.active_width) && (int'(r_a_x) < GRID_WIDTH) &&
                   (5'(r_a_y) < cfg.active_height) && (int'(r_a_y) < GRID_HEIGHT);
        val_ok   = ({1'b0, r_a_v} < cfg.value_count) && (int'(r_a_v) < NUM_VALUES);
        do_obs   = r_a_vld && coord_ok && val_ok && (r_a_act == ACT_OBSERVE);
        priority if (!coord_ok) begin
            st = ST_COORD;
        end else if ((r_a_act == ACT_OBSERVE) && !val_ok) begin
            st = ST_VALUE;
        end else begin
            st = ST_OK;
        end

        xa       = XW'(r_a_x);
        ya       = YW'(r_a_y);
        ctr_bank = bank_of(6'(xa), 6'(ya));
        obs_mask = MASK_W'(1) << r_a_v;

        n_x[ROLE_CENTER] = xa;          n_y[ROLE_CENTER] = ya;
        n_x[ROLE_RIGHT]  = xa + XW'(1); n_y[ROLE_RIGHT]  = ya;
        n_x[ROLE_DOWN]   = xa;          n_y[ROLE_DOWN]   = ya + YW'(1);
        n_x[ROLE_UP]     = xa;          n_y[ROLE_UP]     = ya - YW'(1);
        n_x[ROLE_LEFT]   = xa - XW'(1); n_y[ROLE_LEFT]   = ya;

        n_on[ROLE_CENTER] = 1'b1;
        n_on[ROLE_RIGHT]  = (6'(r_a_x) + 6'd1 < 6'(cfg.active_width)) &&
                            (int'(r_a_x) + 1 < GRID_WIDTH);
        n_on[ROLE_DOWN]   = (6'(r_a_y) + 6'd1 < 6'(cfg.active_height)) &&
                            (int'(r_a_y) + 1 < GRID_HEIGHT);
        n_on[ROLE_UP]     = (r_a_y != 4'd0);
        n_on[ROLE_LEFT]   = (r_a_x != 4'd0);

        n_clr[ROLE_CENTER] = '0;
        n_clr[ROLE_RIGHT]  = clr_mask(cfg, DIR_RIGHT, r_a_v);
        n_clr[ROLE_DOWN]   = clr_mask(cfg, DIR_DOWN, r_a_v);
        n_clr[ROLE_UP]     = clr_mask(cfg, DIR_UP, r_a_v);
        n_clr[ROLE_LEFT]   = clr_mask(cfg, DIR_LEFT, r_a_v);

        for (int o = 0; o < NUM_BANKS; o++) begin
            n_idx[o] = IW'(int'(n_y[o]) * CPR + int'(col_div5(6'(n_x[o]))));
            n_wr[o]  = do_obs && n_on[o] && (n_clr[o] != '0);
            // clear only the struck bits
            n_wen[o] = n_wr[o] ? n_clr[o] : '0;
            n_dat[o] = '0;
        end
        // collapse the addressed tile
        n_wen[ROLE_CENTER] = do_obs ? MASK_ALL : '0;
        n_dat[ROLE_CENTER] = obs_mask;

        for (int k = 0; k < NUM_BANKS; k++) begin
            b_role[k] = sub_mod5(3'(k), ctr_bank);
            if (r_fill) begin
                b_wen[k]   = MASK_ALL;
                b_waddr[k] = r_fill_addr;
                b_wdata[k] = MASK_ALL;
            end else begin
                b_wen[k]   = n_wen[b_role[k]];
                b_waddr[k] = n_idx[b_role[k]];
                b_wdata[k] = n_dat[b_role[k]];
            end
        end
    end

    for (genvar k = 0; k < NUM_BANKS; k++) begin : g_bank
        tgcp_mask_bank #(
            .DEPTH (BDEPTH),
            .AW    (IW),
            .DW    (MASK_W)
        ) u_bank (
            .i_clk   (i_clk),
            .i_wen   (b_wen[k]),
            .i_waddr (b_waddr[k]),
            .i_wdata (b_wdata[k]),
            .i_raddr (n_idx[ROLE_CENTER]),
            .o_rdata (b_rdata[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b_status <= st;
        r_b_rd     <= (r_a_act == ACT_READ);
        r_b_bank   <= ctr_bank;
        r_b_obs    <= obs_mask;
    end

    always_comb begin
        priority if (r_b_status != ST_OK) begin
            out_mask = '0;
        end else if (r_b_rd) begin
            out_mask = b_rdata[r_b_bank];
        end else begin
            out_mask = r_b_obs;
        end
    end

    assign o_done         = r_b_vld;
    assign o_status       = r_b_status;
    assign o_allowed_mask = 4'(out_mask);

endmodule

// ===== dv/tile_grid_constraint_propagator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the tile grid constraint propagator: directed table, then random phases.
module tile_grid_constraint_propagator_tb;
    import tgcp_pkg::*;

    localparam logic [2:0] REG_UNUSED  = 3'd7;
    localparam logic       CHECK_PRED  = 1'b0;
    localparam logic       CHECK_TYPED = 1'b1;
    localparam int         GRID_SIDE   = 16;
    localparam int         NUM_PHASES  = 6;
    localparam int         PHASE_ITEMS = 80;

    typedef struct packed {
        logic [3:0] mask;
        logic [1:0] status;
    } tile_result_t;

    typedef struct packed {
        logic        is_reg;
        logic [2:0]  reg_idx;
        logic [15:0] reg_data;
        logic        act;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [1:0]  v;
        logic        typed;
        logic [3:0]  mask;
        logic [1:0]  status;
    } plan_row_t;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        start          = 1'b0;
    logic        busy;
    logic        i_action       = 1'b0;
    logic [3:0]  i_x_pos        = '0;
    logic [3:0]  i_y_pos        = '0;
    logic [1:0]  i_tile_value   = '0;
    logic        o_done;
    logic [3:0]  o_allowed_mask;
    logic [1:0]  o_status;
    logic        i_cfg_valid    = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index    = '0;
    logic [15:0] i_cfg_data     = '0;

    // Mirror of the tile store and the registers
    logic [3:0]  tile_allow [GRID_SIDE][GRID_SIDE] = '{default: 4'hF};
    logic [4:0]  cfg_cols   = 5'd16;
    logic [4:0]  cfg_rows   = 5'd16;
    logic [2:0]  cfg_values = 3'd4;
    logic [15:0] cfg_forbid [NUM_DIRS] = '{default: '0};

    tile_result_t mask_results_due [$];
    plan_row_t    plan [$];

    logic         item_typed  = 1'b0;
    logic [3:0]   item_mask   = '0;
    logic [1:0]   item_status = '0;

    int items_taken     = 0;
    int results_checked = 0;
    int reg_writes      = 0;
    int settings_run    = 0;
    int errors          = 0;

    tile_grid_constraint_propagator i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_x_pos        (i_x_pos),
        .i_y_pos        (i_y_pos),
        .i_tile_value   (i_tile_value),
        .o_done         (o_done),
        .o_allowed_mask (o_allowed_mask),
        .o_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int grid_cols();
        return (cfg_cols > GRID_SIDE) ? GRID_SIDE : int'(cfg_cols);
    endfunction

    function automatic int grid_rows();
        return (cfg_rows > GRID_SIDE) ? GRID_SIDE : int'(cfg_rows);
    endfunction

    function automatic void clear_neighbor(int x, int y, logic [1:0] dir, int val);
        int nx;
        int ny;
        nx = x;
        ny = y;
        case (dir)
            DIR_UP: begin
                if (y == 0) return;
                ny = y - 1;
            end
            DIR_DOWN: begin
                if (y + 1 >= grid_rows()) return;
                ny = y + 1;
            end
            DIR_LEFT: begin
                if (x == 0) return;
                nx = x - 1;
            end
            default: begin
                if (x + 1 >= grid_cols()) return;
                nx = x + 1;
            end
        endcase
        tile_allow[ny][nx] = tile_allow[ny][nx] & ~(4'b0001 << val);
    endfunction

    function automatic tile_result_t collapse_tile(logic act, logic [3:0] x, logic [3:0] y,
                                                   logic [1:0] v);
        tile_result_t r;
        r.mask   = '0;
        r.status = ST_OK;
        if (int'(x) >= grid_cols() || int'(y) >= grid_rows()) begin
            r.status = ST_COORD;
            return r;
        end
        if (act == ACT_OBSERVE) begin
            if (v >= cfg_values) begin
                r.status = ST_VALUE;
                return r;
            end
            tile_allow[y][x] = 4'b0001 << v;
            for (int d = 0; d < NUM_DIRS; d++) begin
                for (int t = 0; t < FORBID_STRIDE; t++) begin
                    if (cfg_forbid[d][int'(v) * FORBID_STRIDE + t])
                        clear_neighbor(int'(x), int'(y), 2'(d), t);
                    // a neighbor holding t on the far side would forbid v here: drop t there
                    if (cfg_forbid[d][t * FORBID_STRIDE + int'(v)])
                        clear_neighbor(int'(x), int'(y), 2'(d) ^ 2'b01, t);
                end
            end
        end
        r.mask = tile_allow[y][x];
        return r;
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [15:0] data);
        case (idx)
            REG_ACTIVE_WIDTH:  cfg_cols = data[4:0];
            REG_ACTIVE_HEIGHT: cfg_rows = data[4:0];
            REG_VALUE_COUNT:   cfg_values = data[2:0];
            REG_FORBID_UP:     cfg_forbid[DIR_UP] = data;
            REG_FORBID_DOWN:   cfg_forbid[DIR_DOWN] = data;
            REG_FORBID_LEFT:   cfg_forbid[DIR_LEFT] = data;
            REG_FORBID_RIGHT:  cfg_forbid[DIR_RIGHT] = data;
            default: ;
        endcase
    endfunction

    function automatic plan_row_t item_row(logic act, logic [3:0] x, logic [3:0] y,
                                           logic [1:0] v, logic typed, logic [3:0] mask,
                                           logic [1:0] status);
        plan_row_t r;
        r = '0;
        r.act    = act;
        r.x      = x;
        r.y      = y;
        r.v      = v;
        r.typed  = typed;
        r.mask   = mask;
        r.status = status;
        return r;
    endfunction

    function automatic plan_row_t reg_row(logic [2:0] idx, logic [15:0] data);
        plan_row_t r;
        r = '0;
        r.is_reg   = 1'b1;
        r.reg_idx  = idx;
        r.reg_data = data;
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken
    task automatic send_item(logic act, logic [3:0] x, logic [3:0] y, logic [1:0] v,
                             logic typed, logic [3:0] mask, logic [1:0] status);
        i_action     = act;
        i_x_pos      = x;
        i_y_pos      = y;
        i_tile_value = v;
        item_typed   = typed;
        item_mask    = mask;
        item_status  = status;
        start        = 1'b1;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [15:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(idx, data);
        reg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Hold off until every result is back, then let the pipeline drain
    task automatic wait_idle();
        start = 1'b0;
        while (mask_results_due.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        tile_result_t want;
        tile_result_t got;
        if (i_rst_n) begin
            if (start && !busy) begin
                want = collapse_tile(i_action, i_x_pos, i_y_pos, i_tile_value);
                if (item_typed)
                    want = {item_mask, item_status};
                mask_results_due.push_back(want);
                items_taken++;
            end
            if (o_done) begin
                got = {o_allowed_mask, o_status};
                if (mask_results_due.size() == 0) begin
                    errors++;
                    $display("%0t unexpected result: expected none, got mask %h status %0d",
                             $time, got.mask, got.status);
                end else begin
                    want = mask_results_due.pop_front();
                    results_checked++;
                    if (got.mask !== want.mask) begin
                        errors++;
                        $display("%0t allowed_mask mismatch: expected %h, got %h",
                                 $time, want.mask, got.mask);
                    end
                    if (got.status !== want.status) begin
                        errors++;
                        $display("%0t status mismatch: expected %0d, got %0d",
                                 $time, want.status, got.status);
                    end
                end
            end
        end
    end

    initial begin
        #400000;
        $display("[tile_grid_constraint_propagator] ERROR");
        $finish;
    end

    initial begin
        int          idle_pct;
        int          cols;
        int          rows;
        int          vals;
        logic [4:0]  w;
        logic [4:0]  h;
        logic [2:0]  vc;
        logic [15:0] fb [NUM_DIRS];
        logic        act;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [1:0]  v;

        plan = '{
            item_row(ACT_READ,    4'd0,  4'd0,  2'd0, CHECK_TYPED, 4'hF, ST_OK),
            item_row(ACT_READ,    4'd15, 4'd15, 2'd3, CHECK_TYPED, 4'hF, ST_OK),
            item_row(ACT_OBSERVE, 4'd0,  4'd0,  2'd0, CHECK_TYPED, 4'h1, ST_OK),
            item_row(ACT_OBSERVE, 4'd15, 4'd15, 2'd3, CHECK_TYPED, 4'h8, ST_OK),
            item_row(ACT_READ,    4'd0,  4'd0,  2'd1, CHECK_TYPED, 4'h1, ST_OK),
            item_row(ACT_OBSERVE, 4'd0,  4'd15, 2'd2, CHECK_TYPED, 4'h4, ST_OK),
            // shrink the grid; upper data bits must be dropped
            reg_row(REG_ACTIVE_WIDTH,  16'hFFE5),
            reg_row(REG_ACTIVE_HEIGHT, 16'h0003),
            reg_row(REG_VALUE_COUNT,   16'hFFFA),
            reg_row(REG_UNUSED,        16'hFFFF),
            item_row(ACT_READ,    4'd5,  4'd0,  2'd0, CHECK_TYPED, 4'h0, ST_COORD),
            item_row(ACT_OBSERVE, 4'd0,  4'd3,  2'd0, CHECK_TYPED, 4'h0, ST_COORD),
            item_row(ACT_OBSERVE, 4'd15, 4'd15, 2'd3, CHECK_TYPED, 4'h0, ST_COORD),
            item_row(ACT_OBSERVE, 4'd0,  4'd0,  2'd2, CHECK_TYPED, 4'h0, ST_VALUE),
            item_row(ACT_OBSERVE, 4'd4,  4'd2,  2'd3, CHECK_TYPED, 4'h0, ST_VALUE),
            item_row(ACT_READ,    4'd4,  4'd2,  2'd3, CHECK_TYPED, 4'hF, ST_OK),
            reg_row(REG_FORBID_RIGHT, 16'h0040),
            reg_row(REG_FORBID_UP,    16'h0001),
            reg_row(REG_FORBID_DOWN,  16'h8000),
            reg_row(REG_FORBID_LEFT,  16'h0002),
            item_row(ACT_OBSERVE, 4'd1,  4'd1,  2'd1, CHECK_TYPED, 4'h2, ST_OK),
            item_row(ACT_READ,    4'd2,  4'd1,  2'd0, CHECK_PRED,  4'h0, ST_OK),
            item_row(ACT_OBSERVE, 4'd2,  4'd1,  2'd0, CHECK_TYPED, 4'h1, ST_OK),
            item_row(ACT_READ,    4'd1,  4'd1,  2'd0, CHECK_PRED,  4'h0, ST_OK),
            item_row(ACT_READ,    4'd3,  4'd1,  2'd0, CHECK_PRED,  4'h0, ST_OK),
            item_row(ACT_READ,    4'd2,  4'd2,  2'd0, CHECK_PRED,  4'h0, ST_OK),
            reg_row(REG_VALUE_COUNT, 16'h0000),
            item_row(ACT_OBSERVE, 4'd0,  4'd0,  2'd0, CHECK_TYPED, 4'h0, ST_VALUE),
            reg_row(REG_ACTIVE_WIDTH, 16'h0000),
            item_row(ACT_READ,    4'd0,  4'd0,  2'd0, CHECK_TYPED, 4'h0, ST_COORD),
            // oversized register values behave as the full grid
            reg_row(REG_ACTIVE_WIDTH,  16'h001F),
            reg_row(REG_ACTIVE_HEIGHT, 16'h0010),
            reg_row(REG_VALUE_COUNT,   16'h0007),
            item_row(ACT_READ,    4'd15, 4'd15, 2'd0, CHECK_TYPED, 4'h8, ST_OK),
            item_row(ACT_OBSERVE, 4'd15, 4'd0,  2'd3, CHECK_TYPED, 4'h8, ST_OK),
            item_row(ACT_READ,    4'd0,  4'd15, 2'd0, CHECK_TYPED, 4'h4, ST_OK),
            reg_row(REG_FORBID_UP,    16'hFFFF),
            reg_row(REG_FORBID_DOWN,  16'hFFFF),
            reg_row(REG_FORBID_LEFT,  16'hFFFF),
            reg_row(REG_FORBID_RIGHT, 16'hFFFF),
            item_row(ACT_OBSERVE, 4'd7,  4'd7,  2'd0, CHECK_TYPED, 4'h1, ST_OK),
            item_row(ACT_READ,    4'd7,  4'd8,  2'd0, CHECK_PRED,  4'h0, ST_OK),
            item_row(ACT_READ,    4'd6,  4'd7,  2'd0, CHECK_PRED,  4'h0, ST_OK)
        };

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                wait_idle();
                cfg_write(plan[i].reg_idx, plan[i].reg_data);
            end else begin
                send_item(plan[i].act, plan[i].x, plan[i].y, plan[i].v,
                          plan[i].typed, plan[i].mask, plan[i].status);
            end
        end
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            foreach (fb[d])
                fb[d] = 16'($urandom_range(0, 65535));
            case (ph)
                0: begin w = 5'd16; h = 5'd16; vc = 3'd4; end
                1: begin
                    w = 5'd1; h = 5'd1; vc = 3'd1;
                    foreach (fb[d]) fb[d] = 16'hFFFF;
                end
                2: begin w = 5'd3; h = 5'd2; vc = 3'd3; end
                3: begin
                    w = 5'd31; h = 5'd31; vc = 3'd7;
                    foreach (fb[d]) fb[d] = fb[d] & 16'($urandom_range(0, 65535));
                end
                4: begin
                    w  = 5'($urandom_range(1, 31));
                    h  = 5'($urandom_range(1, 31));
                    vc = 3'($urandom_range(0, 7));
                end
                default: begin
                    w = 5'd16; h = 5'd16; vc = 3'd4;
                    foreach (fb[d]) fb[d] = '0;
                end
            endcase
            cfg_write(REG_ACTIVE_WIDTH,  {11'($urandom), w});
            cfg_write(REG_ACTIVE_HEIGHT, {11'($urandom), h});
            cfg_write(REG_VALUE_COUNT,   {13'($urandom), vc});
            cfg_write(REG_FORBID_UP,     fb[DIR_UP]);
            cfg_write(REG_FORBID_DOWN,   fb[DIR_DOWN]);
            cfg_write(REG_FORBID_LEFT,   fb[DIR_LEFT]);
            cfg_write(REG_FORBID_RIGHT,  fb[DIR_RIGHT]);
            cfg_write(REG_UNUSED,        16'($urandom));
            settings_run++;

            idle_pct = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 67 : 12;
            cols = grid_cols();
            rows = grid_rows();
            vals = (cfg_values > 4) ? 4 : int'(cfg_values);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                act = ($urandom_range(0, 99) < 30) ? ACT_READ : ACT_OBSERVE;
                // mostly legal coordinates and values, some noise
                x = (cols > 0 && $urandom_range(0, 99) < 85) ? 4'($urandom_range(0, cols - 1))
                                                            : 4'($urandom_range(0, 15));
                y = (rows > 0 && $urandom_range(0, 99) < 85) ? 4'($urandom_range(0, rows - 1))
                                                            : 4'($urandom_range(0, 15));
                v = (vals > 0 && $urandom_range(0, 99) < 85) ? 2'($urandom_range(0, vals - 1))
                                                            : 2'($urandom_range(0, 3));
                send_item(act, x, y, v, CHECK_PRED, 4'h0, ST_OK);
                if (n == PHASE_ITEMS / 2)
                    wait_idle();
                while ($urandom_range(0, 99) < idle_pct) begin
                    start = 1'b0;
                    @(negedge i_clk);
                end
            end
            wait_idle();
        end

        start = 1'b0;
        for (int n = 0; n < 2000 && mask_results_due.size() != 0; n++) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (mask_results_due.size() != 0) begin
            errors++;
            $display("%0t %0d results never arrived", $time, mask_results_due.size());
        end

        $display("Covered %0d items over %0d random register settings plus directed cases;",
                 items_taken, settings_run);
        $display("%0d results compared, %0d register writes, %0d failures",
                 results_checked, reg_writes, errors);
        if (errors == 0)
            $display("[tile_grid_constraint_propagator] OK");
        else
            $display("[tile_grid_constraint_propagator] ERROR");
        $finish;
    end

endmodule
